// ===== design/uadjt_pkg.sv =====
// Shared types and codes for the undirected adjacency table unit.
// Holds beat structs, operation and status codes, field widths and defaults.
// No dependencies.
package uadjt_pkg;

	localparam int IdW      = 6;
	localparam int SlotW    = 4;
	localparam int DegOutW  = 5;
	localparam int TotalW   = 10;
	localparam int CountW   = 7;

	// Largest vertex id space the command fields can address
	localparam int IdSpace  = 1 << IdW;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_DEGREE_DEF   = 16;
	localparam logic [CountW-1:0] VCOUNT_RST = 7'd64;

	typedef logic [1:0] op_t;
	localparam op_t OP_ADD   = 2'd0;
	localparam op_t OP_TEST  = 2'd1;
	localparam op_t OP_READ  = 2'd2;
	localparam op_t OP_CLEAR = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NOCHANGE = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	typedef struct packed {
		op_t              op;
		logic [IdW-1:0]   vertex_a;
		logic [IdW-1:0]   vertex_b;
		logic [SlotW-1:0] neighbor_slot;
	} cmd_beat_t;

	typedef struct packed {
		status_t            status;
		logic               edge_present;
		logic [DegOutW-1:0] degree_out;
		logic [IdW-1:0]     neighbor_out;
		logic [TotalW-1:0]  edge_total_out;
	} rsp_beat_t;

	typedef struct packed {
		logic [CountW-1:0] active_vertices;
	} cfg_beat_t;

endpackage

// ===== design/uadjt_chan_if.sv =====
// Valid/ready channel carrying one beat of a given payload type.
// Payload types come from uadjt_pkg at the point of instantiation.
interface uadjt_chan_if #(
	parameter type beat_t = logic
);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/undirected_adjacency_table_unit.sv =====
// Undirected adjacency table: per-vertex neighbor lists, degree counts, edge total.
// Depends on uadjt_pkg and the uadjt_chan_if channel interface.
//
//   channel | dir | payload      | beat taken when
//   --------+-----+--------------+---------------------------
//   cfg     | in  | cfg_beat_t   | cfg.valid && cfg.ready
//   cmd     | in  | cmd_beat_t   | cmd.valid && cmd.ready
//   rsp     | out | rsp_beat_t   | rsp.valid && rsp.ready
//
// One command at a time: cmd.ready is high only while the sequencer is idle.
// Add, test and read step through RDA, RDB, CAPB, SCAN and DEC, then FIN; the scan is
// empty (an id out of range or no neighbors of vertex_a), else it reads deg(vertex_a)
// entries. Read adds RDN, a successful add WRA and WRB; clear goes straight to FIN.
// The neighbor scan reads one list entry per cycle through the single read port.
// The result register frees the sequencer; a new command is taken while a result
// waits, and the sequencer stalls at its end while rsp is full.
// Reset (arst_n low) empties all lists at once; cfg is always ready.
module undirected_adjacency_table_unit #(
	parameter int MAX_VERTICES = uadjt_pkg::MAX_VERTICES_DEF,
	parameter int MAX_DEGREE   = uadjt_pkg::MAX_DEGREE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	uadjt_chan_if.sink   cfg,
	uadjt_chan_if.sink   cmd,
	uadjt_chan_if.source rsp
);
	import uadjt_pkg::*;

	localparam int VDEPTH = (MAX_VERTICES < IdSpace) ? MAX_VERTICES : IdSpace;
	localparam int VW     = $clog2(VDEPTH);
	localparam int NDEPTH = VDEPTH * MAX_DEGREE;
	localparam int NAW    = $clog2(NDEPTH);
	localparam int DW     = $clog2(MAX_DEGREE + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_CAPB = 4'd3;
	localparam logic [3:0] S_SCAN = 4'd4;
	localparam logic [3:0] S_DEC  = 4'd5;
	localparam logic [3:0] S_WRA  = 4'd6;
	localparam logic [3:0] S_WRB  = 4'd7;
	localparam logic [3:0] S_RDN  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]        state_q;
	logic [CountW-1:0] vcount_q;
	op_t               op_q;
	logic [IdW-1:0]    a_q;
	logic [IdW-1:0]    b_q;
	logic [SlotW-1:0]  slot_q;
	logic              ok_a_q;
	logic              ok_b_q;
	logic [NAW-1:0]    row_a_q;
	logic [NAW-1:0]    row_b_q;
	logic [DW-1:0]     deg_a_q;
	logic [DW-1:0]     deg_b_q;
	logic [DW-1:0]     lim_q;
	logic [DW-1:0]     idx_q;
	logic              pend_q;
	logic              found_q;
	logic [TotalW-1:0] edge_total_q;
	status_t           status_q;
	logic              present_q;
	logic [DW-1:0]     deg_res_q;
	logic [IdW-1:0]    nbr_q;
	logic              out_vld_q;
	rsp_beat_t         out_q;

	// Storage
	logic [DW-1:0]     deg_mem [VDEPTH];
	logic [VDEPTH-1:0] deg_vld_q;
	logic [DW-1:0]     deg_rd_q;
	logic              vld_rd_q;
	logic [IdW-1:0]    nbr_mem [NDEPTH];
	logic [IdW-1:0]    nbr_rd_q;

	logic           cmd_fire;
	logic           ok_a_in;
	logic           ok_b_in;
	logic [DW-1:0]  deg_eff;
	logic [VW-1:0]  deg_raddr;
	logic [NAW-1:0] nbr_raddr;
	logic           mem_we;
	logic           wr_sel;
	logic [NAW-1:0] nbr_waddr;
	logic [IdW-1:0] nbr_wdata;
	logic [VW-1:0]  deg_waddr;
	logic [DW-1:0]  deg_wdata;
	logic           slot_bad;
	logic           rsp_free;

	// Handshakes
	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;
	assign rsp_free  = !out_vld_q || rsp.ready;

	// Range check against the configured count and the table size
	assign ok_a_in = (32'(cmd.data.vertex_a) < 32'(vcount_q)) &&
		(32'(cmd.data.vertex_a) < MAX_VERTICES);
	assign ok_b_in = (32'(cmd.data.vertex_b) < 32'(vcount_q)) &&
		(32'(cmd.data.vertex_b) < MAX_VERTICES);

	// A never-written degree entry reads as zero
	assign deg_eff   = vld_rd_q ? deg_rd_q : '0;
	assign deg_raddr = (state_q == S_RDB) ? b_q[VW-1:0] : a_q[VW-1:0];
	assign nbr_raddr = (state_q == S_SCAN) ? (row_a_q + NAW'(idx_q)) :
		(row_a_q + NAW'(slot_q));
	assign slot_bad  = (32'(slot_q) >= 32'(deg_a_q)) || (32'(slot_q) >= MAX_DEGREE);

	// Append: first endpoint's list, then the second's
	assign mem_we    = (state_q == S_WRA) || (state_q == S_WRB);
	assign wr_sel    = (state_q == S_WRB);
	assign nbr_waddr = wr_sel ? (row_b_q + NAW'(deg_b_q)) : (row_a_q + NAW'(deg_a_q));
	assign nbr_wdata = wr_sel ? a_q : b_q;
	assign deg_waddr = wr_sel ? b_q[VW-1:0] : a_q[VW-1:0];
	assign deg_wdata = (wr_sel ? deg_b_q : deg_a_q) + DW'(1);

	// Table memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			nbr_mem[nbr_waddr] <= nbr_wdata;
			deg_mem[deg_waddr] <= deg_wdata;
		end
		nbr_rd_q <= nbr_mem[nbr_raddr];
		deg_rd_q <= deg_mem[deg_raddr];
	end

	// Sequencer, config register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vcount_q     <= VCOUNT_RST;
			op_q         <= OP_ADD;
			a_q          <= '0;
			b_q          <= '0;
			slot_q       <= '0;
			ok_a_q       <= 1'b0;
			ok_b_q       <= 1'b0;
			row_a_q      <= '0;
			row_b_q      <= '0;
			deg_a_q      <= '0;
			deg_b_q      <= '0;
			lim_q        <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			found_q      <= 1'b0;
			edge_total_q <= '0;
			status_q     <= ST_DONE;
			present_q    <= 1'b0;
			deg_res_q    <= '0;
			nbr_q        <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
			deg_vld_q    <= '0;
			vld_rd_q     <= 1'b0;
		end else begin
			vld_rd_q <= deg_vld_q[deg_raddr];

			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.data.active_vertices;
			end

			// Drop the result once taken, unless a new one replaces it
			if (out_vld_q && rsp.ready && (state_q != S_FIN)) begin
				out_vld_q <= 1'b0;
			end

			// Mark degree entries written by an append
			if (mem_we) begin
				deg_vld_q[deg_waddr] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						op_q    <= cmd.data.op;
						a_q     <= cmd.data.vertex_a;
						b_q     <= cmd.data.vertex_b;
						slot_q  <= cmd.data.neighbor_slot;
						ok_a_q  <= ok_a_in;
						ok_b_q  <= ok_b_in;
						row_a_q <= NAW'(cmd.data.vertex_a) * NAW'(MAX_DEGREE);
						row_b_q <= NAW'(cmd.data.vertex_b) * NAW'(MAX_DEGREE);
						if (cmd.data.op == OP_CLEAR) begin
							deg_vld_q    <= '0;
							edge_total_q <= '0;
							status_q     <= ST_DONE;
							present_q    <= 1'b0;
							deg_res_q    <= '0;
							nbr_q        <= '0;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					deg_a_q <= deg_eff;
					state_q <= S_CAPB;
				end
				S_CAPB: begin
					deg_b_q <= deg_eff;
					lim_q   <= (ok_a_q && ok_b_q) ? deg_a_q : '0;
					idx_q   <= '0;
					pend_q  <= 1'b0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// Issue one list read per cycle, compare the one returned
					if (idx_q < lim_q) begin
						idx_q  <= idx_q + DW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && (nbr_rd_q == b_q)) begin
						found_q <= 1'b1;
					end
					if (!(idx_q < lim_q) && !pend_q) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					present_q <= ok_a_q && ok_b_q && found_q;
					deg_res_q <= ok_a_q ? deg_a_q : '0;
					nbr_q     <= '0;
					state_q   <= S_FIN;
					unique case (op_q)
						OP_ADD: begin
							priority if (a_q == b_q) begin
								status_q <= ST_NOCHANGE;
							end else if (!(ok_a_q && ok_b_q)) begin
								status_q <= ST_RANGE;
							end else if (found_q) begin
								status_q <= ST_NOCHANGE;
							end else if ((32'(deg_a_q) >= MAX_DEGREE) ||
								(32'(deg_b_q) >= MAX_DEGREE)) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_DONE;
								state_q  <= S_WRA;
							end
						end
						OP_TEST: begin
							status_q <= (ok_a_q && ok_b_q) ? ST_DONE : ST_RANGE;
						end
						OP_READ: begin
							status_q <= (!ok_a_q || slot_bad) ? ST_RANGE : ST_DONE;
							state_q  <= S_RDN;
						end
						OP_CLEAR: begin
							status_q <= ST_DONE;
						end
					endcase
				end
				S_WRA: begin
					state_q <= S_WRB;
				end
				S_WRB: begin
					edge_total_q <= edge_total_q + TotalW'(1);
					status_q     <= ST_DONE;
					present_q    <= 1'b1;
					deg_res_q    <= deg_a_q + DW'(1);
					state_q      <= S_FIN;
				end
				S_RDN: begin
					nbr_q   <= (status_q == ST_DONE) ? nbr_rd_q : '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// Hold until the result register has room
					if (rsp_free) begin
						out_q.status         <= status_q;
						out_q.edge_present   <= present_q;
						out_q.degree_out     <= DegOutW'(deg_res_q);
						out_q.neighbor_out   <= nbr_q;
						out_q.edge_total_out <= edge_total_q;
						out_vld_q            <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q == S_RDA) || (state_q == S_FIN))
		else $error("command did not start the sequencer");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_WRB) && !(cmd_fire && (cmd.data.op == OP_CLEAR)))
		|=> $stable(edge_total_q))
		else $error("edge total changed outside append or clear");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRA) |-> (deg_a_q < DW'(MAX_DEGREE)) && (deg_b_q < DW'(MAX_DEGREE)))
		else $error("append into a full list");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= lim_q))
		else $error("scan index passed its limit");

	a_append_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB) |=> (status_q == ST_DONE) && present_q)
		else $error("append did not report an added edge");
`endif

endmodule
